@@ hw/rtl/hdh_pkg.sv @@
// shared types and constants of the hermite delay history unit
package hdh_pkg;

  localparam int TIME_W   = 32;
  localparam int VAL_W    = 32;
  localparam int MASK_W   = 4;
  localparam int MAX_COMP = 4;
  localparam int TOL_W    = 16;
  localparam int HLEN_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W    = 64;
  localparam int PROD_W   = 128;
  localparam int TH_W     = 16;
  localparam int RES_DEPTH = 4;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 7'd64;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HISTORY_LENGTH  = 2'd0,
    CFG_MATCH_TOLERANCE = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_ADD_WR,
    ST_ADD_OLD,
    ST_SCAN,
    ST_CHK,
    ST_HIT,
    ST_BRK,
    ST_UPA,
    ST_LOR,
    ST_UPR,
    ST_HCHK,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_COEF,
    ST_CSEL,
    ST_CMUL,
    ST_FIN,
    ST_PUSH
  } back_state_e;

  typedef struct packed {
    op_e                      op;
    logic signed [TIME_W-1:0] time_point;
    logic [MASK_W-1:0]        component_mask;
    logic signed [VAL_W-1:0]  sol_0;
    logic signed [VAL_W-1:0]  sol_1;
    logic signed [VAL_W-1:0]  sol_2;
    logic signed [VAL_W-1:0]  sol_3;
    logic signed [VAL_W-1:0]  der_0;
    logic signed [VAL_W-1:0]  der_1;
    logic signed [VAL_W-1:0]  der_2;
    logic signed [VAL_W-1:0]  der_3;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] delayed_value;
    logic [1:0]              component;
    logic                    last;
    logic                    exact_hit;
    logic                    interval_bad;
  } res_item_t;

  typedef struct packed {
    op_e                              op;
    logic signed [TIME_W-1:0]         time_point;
    logic [MASK_W-1:0]                component_mask;
    logic [MAX_COMP-1:0][VAL_W-1:0]   sol;
    logic [MAX_COMP-1:0][VAL_W-1:0]   der;
  } cmd_t;

endpackage

@@ hw/rtl/hdh_mul.sv @@
// sequential signed multiplier, 64 x 16 bit partial product per cycle
module hdh_mul import hdh_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic              busy_q, busy_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              pv_q, pv_d;
  logic              done_q, done_d;
  logic [MUL_W-1:0]  ma_q, ma_d, mb_q, mb_d;
  logic              neg_q, neg_d;
  logic [MUL_W+15:0] pp_q, pp_d;
  logic [1:0]        psh_q, psh_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    pv_d   = 1'b0;
    done_d = 1'b0;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    pp_d   = pp_q;
    psh_d  = psh_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    if (start_i) begin
      ma_d   = a_i[MUL_W-1] ? (MUL_W'(0) - a_i) : a_i;
      mb_d   = b_i[MUL_W-1] ? (MUL_W'(0) - b_i) : b_i;
      neg_d  = a_i[MUL_W-1] ^ b_i[MUL_W-1];
      cnt_d  = '0;
      busy_d = 1'b1;
      acc_d  = '0;
    end else if (busy_q) begin
      if (pv_q) begin
        acc_d = acc_q + ({48'b0, pp_q} << {psh_q, 4'b0});
      end
      if (cnt_q < 3'd4) begin
        pp_d  = ma_q * mb_q[{cnt_q[1:0], 4'b0} +: 16];
        pv_d  = 1'b1;
        psh_d = cnt_q[1:0];
        cnt_d = cnt_q + 3'd1;
      end else if (cnt_q == 3'd4) begin
        cnt_d = cnt_q + 3'd1;
      end else begin
        prod_d = neg_q ? (PROD_W'(0) - acc_q) : acc_q;
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      pv_q   <= pv_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    neg_q  <= neg_d;
    pp_q   <= pp_d;
    psh_q  <= psh_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ hw/rtl/hdh_front.sv @@
// input side: accepts items, drops empty queries, two-entry command queue
module hdh_front import hdh_pkg::*; #(
  parameter int COMPONENTS = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t in_item_i,
  input  logic     clearing_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  localparam logic [MASK_W-1:0] CompMask = MASK_W'((1 << COMPONENTS) - 1);

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       take, keep, deq;

  always_comb begin
    cmd_in.op             = in_item_i.op;
    cmd_in.time_point     = in_item_i.time_point;
    cmd_in.component_mask = in_item_i.component_mask & CompMask;
    cmd_in.sol            = {in_item_i.sol_3, in_item_i.sol_2, in_item_i.sol_1, in_item_i.sol_0};
    cmd_in.der            = {in_item_i.der_3, in_item_i.der_2, in_item_i.der_1, in_item_i.der_0};
  end

  assign full_o      = (cnt_q == 2'd2) || clearing_i;
  assign take        = push_i && !full_o;
  // a query asking for no valid component has no effect at all
  assign keep        = take && !((cmd_in.op == OP_QUERY) && (cmd_in.component_mask == '0));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign deq         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (keep) wr_q <= ~wr_q;
      if (deq)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(keep) - 2'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) slot_q[wr_q] <= cmd_in;
  end

endmodule

@@ hw/rtl/hdh_res_fifo.sv @@
// result queue between the engine and the output port
module hdh_res_fifo import hdh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output res_item_t item_o
);

  localparam int PW = $clog2(RES_DEPTH);

  res_item_t   ent_q [RES_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(RES_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= item_i;
  end

endmodule

@@ hw/rtl/hdh_back.sv @@
// engine: ring store, nearest-time scan, bracket, divide and hermite evaluation
module hdh_back import hdh_pkg::*; #(
  parameter  int DEPTH      = 64,
  parameter  int COMPONENTS = 4,
  localparam int AW         = $clog2(DEPTH),
  localparam int XW         = AW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [XW-1:0]    len_i,
  input  logic [TOL_W-1:0] tol_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_ready_o,
  output logic             clearing_o,
  output logic             res_push_o,
  output res_item_t        res_o,
  input  logic             res_full_i
);

  localparam int RW = TIME_W + 2 * VAL_W * COMPONENTS;
  localparam int CW = $clog2(XW + 1);

  back_state_e state_q, state_d, ret_q, ret_d;

  // storage
  logic [RW-1:0] mem_q [DEPTH];
  logic [RW-1:0] rd_row_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wrow;

  logic [AW-1:0] clr_q, clr_d;
  logic [XW-1:0] mod_x_q, mod_x_d, mod_r_q, mod_r_d, mod_r2;
  logic [CW-1:0] mod_cnt_q, mod_cnt_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [XW-1:0] count_q, count_d;
  logic          full_q, full_d;
  cmd_t          cur_q, cur_d;
  logic [XW-1:0] si_q, si_d;
  logic          sv_q, sv_d;
  logic [AW-1:0] sidx_q, sidx_d;
  logic [TIME_W:0] best_q, best_d;
  logic [AW-1:0] near_q, near_d;
  logic signed [TIME_W-1:0] near_t_q, near_t_d;
  logic          hit_q, hit_d, bad_q, bad_d;
  logic [AW-1:0] lo_q, lo_d, up_q, up_d, lo_sel;
  logic [RW-1:0] row_lo_q, row_lo_d, row_up_q, row_up_d;
  logic signed [TIME_W:0] h_q, h_d, ht_q, ht_d;
  logic [TIME_W+1:0] div_r_q, div_r_d, div_r2;
  logic [TH_W-1:0] th_q, th_d;
  logic [3:0]    div_cnt_q, div_cnt_d;
  logic [MUL_W-1:0] t2_q, t2_d, t3_q, t3_d;
  logic signed [MUL_W-1:0] c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;
  logic [1:0]    k_q, k_d;
  logic [2:0]    j_q, j_d;
  logic signed [MUL_W-1:0] hd0_q, hd0_d, hd1_q, hd1_d;
  logic signed [PROD_W-1:0] acc_q, acc_d, rnd;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic          mbusy_q, mbusy_d;

  logic                    mul_start, mul_done;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [TIME_W-1:0] rd_time, lo_time;
  logic signed [TIME_W:0]   tdiff;
  logic [TIME_W:0]          adist;
  logic signed [VAL_W-1:0]  sol_lo [MAX_COMP];
  logic signed [VAL_W-1:0]  sol_up [MAX_COMP];
  logic signed [VAL_W-1:0]  der_lo [MAX_COMP];
  logic signed [VAL_W-1:0]  der_up [MAX_COMP];
  logic [MASK_W-1:0]        above;
  logic                     is_last, want;
  logic [MUL_W-1:0]         t2s, t1;
  logic signed [MUL_W-1:0]  hi;

  hdh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  for (genvar c = 0; c < MAX_COMP; c++) begin : g_unpack
    if (c < COMPONENTS) begin : g_used
      assign sol_lo[c] = row_lo_q[TIME_W + VAL_W*c +: VAL_W];
      assign sol_up[c] = row_up_q[TIME_W + VAL_W*c +: VAL_W];
      assign der_lo[c] = row_lo_q[TIME_W + VAL_W*(COMPONENTS+c) +: VAL_W];
      assign der_up[c] = row_up_q[TIME_W + VAL_W*(COMPONENTS+c) +: VAL_W];
      assign wrow[TIME_W + VAL_W*c +: VAL_W] =
        (state_q == ST_CLR) ? '0 : cur_q.sol[c];
      assign wrow[TIME_W + VAL_W*(COMPONENTS+c) +: VAL_W] =
        (state_q == ST_CLR) ? '0 : cur_q.der[c];
    end else begin : g_unused
      assign sol_lo[c] = '0;
      assign sol_up[c] = '0;
      assign der_lo[c] = '0;
      assign der_up[c] = '0;
    end
  end
  assign wrow[TIME_W-1:0] = (state_q == ST_CLR) ? '0 : cur_q.time_point;

  assign rd_time = rd_row_q[TIME_W-1:0];
  assign lo_time = row_lo_q[TIME_W-1:0];
  assign tdiff   = {rd_time[TIME_W-1], rd_time} - {cur_q.time_point[TIME_W-1], cur_q.time_point};
  assign adist   = tdiff[TIME_W] ? ((TIME_W+1)'(0) - tdiff) : tdiff;
  assign mod_r2  = {mod_r_q[XW-2:0], mod_x_q[XW-1]};
  assign div_r2  = {div_r_q[TIME_W:0], 1'b0};
  assign above   = cur_q.component_mask >> k_q;
  assign is_last = (above[MASK_W-1:1] == '0);
  assign want    = cur_q.component_mask[k_q];
  assign t2s     = t2_q << 16;
  assign t1      = MUL_W'(th_q) << 32;
  assign rnd     = acc_q + (PROD_W'(1) << 63);
  assign hi      = rnd[PROD_W-1:MUL_W];

  // bracket lower end from the nearest slot and the oldest entry
  always_comb begin
    if ((near_t_q == '0) && ($signed(rd_time) <= 0)) begin
      lo_sel = oldest_q;
    end else if (near_t_q > cur_q.time_point) begin
      lo_sel = (near_q == '0) ? AW'(len_i - XW'(1)) : (near_q - AW'(1));
    end else begin
      lo_sel = near_q;
    end
  end

  assign clearing_o = (state_q == ST_CLR);
  assign res_o.delayed_value = val_q;
  assign res_o.component     = k_q;
  assign res_o.last          = is_last;
  assign res_o.exact_hit     = hit_q;
  assign res_o.interval_bad  = bad_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:     if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) state_d = (cmd_i.op == OP_ADD) ? ST_MOD : ST_SCAN;
      end
      ST_MOD:     if (mod_cnt_q == CW'(XW - 1)) state_d = ret_q;
      ST_ADD_WR:  state_d = full_q ? ST_MOD : ST_IDLE;
      ST_ADD_OLD: state_d = ST_IDLE;
      ST_SCAN: begin
        if (sv_q && (XW'(sidx_q) == len_i - XW'(1))) state_d = ST_CHK;
      end
      ST_CHK:     state_d = (best_q <= (TIME_W+1)'(tol_i)) ? ST_HIT : ST_BRK;
      ST_HIT:     state_d = ST_CSEL;
      ST_BRK:     state_d = ST_MOD;
      ST_UPA:     state_d = ST_LOR;
      ST_LOR:     state_d = ST_UPR;
      ST_UPR:     state_d = ST_HCHK;
      ST_HCHK: begin
        if (h_q <= 0) state_d = ST_CSEL;
        else if ((ht_q <= 0) || (ht_q >= h_q)) state_d = ST_SQ;
        else state_d = ST_DIV;
      end
      ST_DIV:     if (div_cnt_q == 4'd15) state_d = ST_SQ;
      ST_SQ:      if (mul_done) state_d = ST_CUBE;
      ST_CUBE:    if (mul_done) state_d = ST_COEF;
      ST_COEF:    state_d = ST_CSEL;
      ST_CSEL: begin
        if (want) state_d = (hit_q || bad_q) ? ST_PUSH : ST_CMUL;
      end
      ST_CMUL:    if (mul_done && (j_q == 3'd5)) state_d = ST_FIN;
      ST_FIN:     state_d = ST_PUSH;
      ST_PUSH: begin
        if (!res_full_i) state_d = is_last ? ST_IDLE : ST_CSEL;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_d = ret_q;  clr_d = clr_q;  mod_x_d = mod_x_q;  mod_r_d = mod_r_q;
    mod_cnt_d = mod_cnt_q;  oldest_d = oldest_q;  count_d = count_q;  full_d = full_q;
    cur_d = cur_q;  si_d = si_q;  sv_d = 1'b0;  sidx_d = sidx_q;  best_d = best_q;
    near_d = near_q;  near_t_d = near_t_q;  hit_d = hit_q;  bad_d = bad_q;
    lo_d = lo_q;  up_d = up_q;  row_lo_d = row_lo_q;  row_up_d = row_up_q;
    h_d = h_q;  ht_d = ht_q;  div_r_d = div_r_q;  th_d = th_q;  div_cnt_d = div_cnt_q;
    t2_d = t2_q;  t3_d = t3_q;  c00_d = c00_q;  c01_d = c01_q;  c10_d = c10_q;
    c11_d = c11_q;  k_d = k_q;  j_d = j_q;  hd0_d = hd0_q;  hd1_d = hd1_q;
    acc_d = acc_q;  val_d = val_q;  mbusy_d = mbusy_q;
    we = 1'b0;  waddr = '0;  raddr = '0;
    cmd_ready_o = 1'b0;  res_push_o = 1'b0;
    mul_start = 1'b0;  mul_a = '0;  mul_b = '0;
    unique case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          k_d   = '0;
          hit_d = 1'b0;
          bad_d = 1'b0;
          si_d  = '0;
          mod_x_d   = XW'(oldest_q) + count_q;
          mod_r_d   = '0;
          mod_cnt_d = '0;
          ret_d     = ST_ADD_WR;
        end
      end
      ST_MOD: begin
        mod_r_d   = (mod_r2 >= len_i) ? (mod_r2 - len_i) : mod_r2;
        mod_x_d   = mod_x_q << 1;
        mod_cnt_d = mod_cnt_q + CW'(1);
      end
      ST_ADD_WR: begin
        we    = 1'b1;
        waddr = mod_r_q[AW-1:0];
        if (full_q) begin
          mod_x_d   = XW'(oldest_q) + XW'(1);
          mod_r_d   = '0;
          mod_cnt_d = '0;
          ret_d     = ST_ADD_OLD;
        end else begin
          count_d = count_q + XW'(1);
          full_d  = (count_q + XW'(1)) >= len_i;
        end
      end
      ST_ADD_OLD: oldest_d = mod_r_q[AW-1:0];
      ST_SCAN: begin
        raddr  = si_q[AW-1:0];
        sv_d   = (si_q < len_i);
        sidx_d = si_q[AW-1:0];
        if (si_q < len_i) si_d = si_q + XW'(1);
        // strict compare keeps the lowest index on ties
        if (sv_q && ((sidx_q == '0) || (adist < best_q))) begin
          best_d   = adist;
          near_d   = sidx_q;
          near_t_d = rd_time;
        end
      end
      ST_CHK: begin
        hit_d = (best_q <= (TIME_W+1)'(tol_i));
        raddr = (best_q <= (TIME_W+1)'(tol_i)) ? near_q : oldest_q;
      end
      ST_HIT: row_lo_d = rd_row_q;
      ST_BRK: begin
        lo_d      = lo_sel;
        mod_x_d   = XW'(lo_sel) + XW'(1);
        mod_r_d   = '0;
        mod_cnt_d = '0;
        ret_d     = ST_UPA;
      end
      ST_UPA: begin
        up_d  = mod_r_q[AW-1:0];
        raddr = lo_q;
      end
      ST_LOR: begin
        row_lo_d = rd_row_q;
        raddr    = up_q;
      end
      ST_UPR: begin
        row_up_d = rd_row_q;
        h_d  = {rd_time[TIME_W-1], rd_time} - {lo_time[TIME_W-1], lo_time};
        ht_d = {cur_q.time_point[TIME_W-1], cur_q.time_point} - {lo_time[TIME_W-1], lo_time};
      end
      ST_HCHK: begin
        th_d      = '0;
        div_r_d   = {1'b0, ht_q};
        div_cnt_d = '0;
        if (h_q <= 0) bad_d = 1'b1;
        else if (ht_q >= h_q) th_d = '1;
      end
      ST_DIV: begin
        if (div_r2 >= {1'b0, h_q}) begin
          div_r_d = div_r2 - {1'b0, h_q};
          th_d    = {th_q[TH_W-2:0], 1'b1};
        end else begin
          div_r_d = div_r2;
          th_d    = {th_q[TH_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 4'd1;
      end
      ST_SQ: begin
        mul_a = MUL_W'(th_q);
        mul_b = MUL_W'(th_q);
        if (!mbusy_q) begin
          mul_start = 1'b1;
          mbusy_d   = 1'b1;
        end
        if (mul_done) begin
          t2_d    = mul_p[MUL_W-1:0];
          mbusy_d = 1'b0;
        end
      end
      ST_CUBE: begin
        mul_a = t2_q;
        mul_b = MUL_W'(th_q);
        if (!mbusy_q) begin
          mul_start = 1'b1;
          mbusy_d   = 1'b1;
        end
        if (mul_done) begin
          t3_d    = mul_p[MUL_W-1:0];
          mbusy_d = 1'b0;
        end
      end
      ST_COEF: begin
        c00_d = (t3_q << 1) - ((t2s << 1) + t2s) + (MUL_W'(1) << 48);
        c01_d = ((t2s << 1) + t2s) - (t3_q << 1);
        c10_d = t3_q - (t2s << 1) + t1;
        c11_d = t3_q - t2s;
      end
      ST_CSEL: begin
        if (!want) begin
          k_d = k_q + 2'd1;
        end else if (hit_q) begin
          val_d = sol_lo[k_q];
        end else if (bad_q) begin
          val_d = '0;
        end else begin
          j_d   = '0;
          acc_d = '0;
        end
      end
      ST_CMUL: begin
        unique case (j_q)
          3'd0: begin
            mul_a = MUL_W'(h_q);
            mul_b = MUL_W'(der_lo[k_q]);
          end
          3'd1: begin
            mul_a = MUL_W'(h_q);
            mul_b = MUL_W'(der_up[k_q]);
          end
          3'd2: begin
            mul_a = c00_q;
            mul_b = MUL_W'($signed({sol_lo[k_q], 16'b0}));
          end
          3'd3: begin
            mul_a = c01_q;
            mul_b = MUL_W'($signed({sol_up[k_q], 16'b0}));
          end
          3'd4: begin
            mul_a = c10_q;
            mul_b = hd0_q;
          end
          default: begin
            mul_a = c11_q;
            mul_b = hd1_q;
          end
        endcase
        if (!mbusy_q) begin
          mul_start = 1'b1;
          mbusy_d   = 1'b1;
        end
        if (mul_done) begin
          mbusy_d = 1'b0;
          j_d     = j_q + 3'd1;
          if (j_q == 3'd0) hd0_d = mul_p[MUL_W-1:0];
          else if (j_q == 3'd1) hd1_d = mul_p[MUL_W-1:0];
          else acc_d = acc_q + mul_p;
        end
      end
      ST_FIN: begin
        // round half up at bit 64, then saturate to 32 bits
        if (hi < -64'sd2147483648) val_d = 32'sh8000_0000;
        else if (hi > 64'sd2147483647) val_d = 32'sh7fff_ffff;
        else val_d = hi[VAL_W-1:0];
      end
      ST_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (!is_last) k_d = k_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wrow;
    rd_row_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      ret_q     <= ST_IDLE;
      clr_q     <= '0;
      mod_cnt_q <= '0;
      oldest_q  <= '0;
      count_q   <= '0;
      full_q    <= 1'b0;
      si_q      <= '0;
      sv_q      <= 1'b0;
      hit_q     <= 1'b0;
      bad_q     <= 1'b0;
      div_cnt_q <= '0;
      k_q       <= '0;
      j_q       <= '0;
      mbusy_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      clr_q     <= clr_d;
      mod_cnt_q <= mod_cnt_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      full_q    <= full_d;
      si_q      <= si_d;
      sv_q      <= sv_d;
      hit_q     <= hit_d;
      bad_q     <= bad_d;
      div_cnt_q <= div_cnt_d;
      k_q       <= k_d;
      j_q       <= j_d;
      mbusy_q   <= mbusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_x_q  <= mod_x_d;
    mod_r_q  <= mod_r_d;
    cur_q    <= cur_d;
    sidx_q   <= sidx_d;
    best_q   <= best_d;
    near_q   <= near_d;
    near_t_q <= near_t_d;
    lo_q     <= lo_d;
    up_q     <= up_d;
    row_lo_q <= row_lo_d;
    row_up_q <= row_up_d;
    h_q      <= h_d;
    ht_q     <= ht_d;
    div_r_q  <= div_r_d;
    th_q     <= th_d;
    t2_q     <= t2_d;
    t3_q     <= t3_d;
    c00_q    <= c00_d;
    c01_q    <= c01_d;
    c10_q    <= c10_d;
    c11_q    <= c11_d;
    hd0_q    <= hd0_d;
    hd1_q    <= hd1_d;
    acc_q    <= acc_d;
    val_q    <= val_d;
  end

endmodule

@@ hw/rtl/hermite_delay_history_unit.sv @@
// top level of the hermite delay history unit: config registers and channel wiring
//
//   channel  | direction | handshake            | payload
//   input    | in        | push / full          | in_item_i  (in_item_t)
//   result   | out       | empty / pop          | res_item_o (res_item_t)
//   config   | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//
// an add runs the bit-serial slot modulo to find its write slot; once the ring is full a
// second modulo advances the oldest entry
// a query scans all L slots for the nearest time, then brackets, divides and forms the
// coefficients before its first component (no divide when theta clamps, none of these on
// an exact hit, none after the bracket on a bad interval); each requested component then
// uses the shared multiplier, save on a hit or bad interval; skipped mask bits are passed
// after reset a clearing pass zeroes the store; no item is taken meanwhile
// the command queue takes up to two items while the engine works or the result queue is full
module hermite_delay_history_unit import hdh_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int COMPONENTS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output res_item_t             res_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = AW + 1;

  logic [HLEN_W-1:0] hlen_q;
  logic [TOL_W-1:0]  tol_q;
  logic [31:0]       hlen32;
  logic [XW-1:0]     len;
  logic              cmd_valid, cmd_ready, clearing, res_push, res_full;
  cmd_t              cmd;
  res_item_t         res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlen_q <= HLEN_RESET;
      tol_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HISTORY_LENGTH:  hlen_q <= cfg_data_i[HLEN_W-1:0];
        CFG_MATCH_TOLERANCE: tol_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ring length limited to [2, DEPTH]
  assign hlen32 = 32'(hlen_q);
  always_comb begin
    if (hlen32 < 32'd2) len = XW'(2);
    else if (hlen32 > 32'(DEPTH)) len = XW'(DEPTH);
    else len = XW'(hlen32);
  end

  hdh_front #(.COMPONENTS(COMPONENTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .clearing_i  (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  hdh_back #(.DEPTH(DEPTH), .COMPONENTS(COMPONENTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len),
    .tol_i       (tol_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .clearing_o  (clearing),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  hdh_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (res_item_o)
  );

endmodule
